// File: design/dcef_pkg.sv
// ----------------------------------------------------------------------------
// dcef_pkg: shared constants and types of the depth clamp and erosion filter
// geometry limits, field widths, register map and line store word layout
// ----------------------------------------------------------------------------
package dcef_pkg;

	// geometry limits
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_WINDOW  = 7;
	localparam int DEPTH_BITS  = 16;
	localparam int MAX_RAD     = (MAX_WINDOW - 1) / 2;

	// mask layout, always a centred 7x7 grid
	localparam int MASK_SIDE   = 7;
	localparam int MASK_CENTRE = 3;
	localparam int MASK_BITS   = MASK_SIDE * MASK_SIDE;

	// field and register widths
	localparam int DEPTH_W     = 16;
	localparam int DIM_W       = 11;
	localparam int RAD_W       = 2;

	// internal widths
	localparam int LB_ROWS     = MAX_WINDOW - 1;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int IN_ROW_W    = $clog2(MAX_HEIGHT + 2 * MAX_RAD + 1);
	localparam int LAG_W       = $clog2(MAX_RAD * MAX_WIDTH + MAX_RAD + 1);
	localparam int POS_W       = DIM_W + 1;

	// register port
	localparam int APB_DW      = 64;
	localparam int APB_AW      = 6;
	localparam int REG_ALIGN   = 3;
	localparam int IDX_W       = APB_AW - REG_ALIGN;

	// register reset values
	localparam logic [DIM_W-1:0]     RST_WIDTH   = DIM_W'(640);
	localparam logic [DIM_W-1:0]     RST_HEIGHT  = DIM_W'(360);
	localparam logic [DEPTH_W-1:0]   RST_FLOOR   = DEPTH_W'(200);
	localparam logic [DEPTH_W-1:0]   RST_CEILING = DEPTH_W'(8000);
	localparam logic [RAD_W-1:0]     RST_RADIUS  = RAD_W'(2);
	localparam logic [MASK_BITS-1:0] RST_MASK    = MASK_BITS'(64'd291651945472);

	typedef logic [DEPTH_BITS-1:0] depth_t;

	// one line store word: the rows above, nearest row in entry 0
	typedef logic [LB_ROWS-1:0][DEPTH_BITS-1:0] lb_word_t;

	// one window column: current row in entry 0, older rows above it
	typedef logic [MAX_WINDOW-1:0][DEPTH_BITS-1:0] win_col_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_DEPTH_FLOOR   = 3'd2,
		REG_DEPTH_CEILING = 3'd3,
		REG_WINDOW_RADIUS = 3'd4,
		REG_WINDOW_MASK   = 3'd5
	} reg_idx_t;

endpackage

// File: design/dcef_stream_if.sv
// ----------------------------------------------------------------------------
// dcef stream interfaces
// valid/ready channels for depth pixel beats in and eroded result beats out
// ----------------------------------------------------------------------------
interface dcef_pix_if import dcef_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_mm;
	logic               flush_tick;

	modport source (output valid, output depth_mm, output flush_tick, input ready);
	modport sink   (input valid, input depth_mm, input flush_tick, output ready);
endinterface

interface dcef_res_if import dcef_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] eroded_depth_mm;
	logic               frame_done;

	modport source (output valid, output eroded_depth_mm, output frame_done, input ready);
	modport sink   (input valid, input eroded_depth_mm, input frame_done, output ready);
endinterface

// File: design/depth_clamp_erode_filter.sv
// ----------------------------------------------------------------------------
// depth_clamp_erode_filter: depth clamp and masked grey-scale erosion
// replaces out-of-range depths by the ceiling, then takes the minimum over
// a masked square window clipped to the frame; while the skid is empty, one pixel beat per clock
// ----------------------------------------------------------------------------
//
// channel  | dir | beat payload                   | handshake
// ---------+-----+--------------------------------+-------------------------
// pix      | in  | depth_mm[15:0], flush_tick     | valid & ready
// res      | out | eroded_depth_mm[15:0], frame_done | valid & ready
// apb      | in  | 64-bit register writes/reads   | psel & penable, pready=1
//
// one pixel beat per clock while the skid is empty; a result reaches the output
// register after the line store read, window shift, column minimum and row
// minimum steps, in that order
// reset clears counters and handshake state and loads the register reset values; the line store needs no
// clearing pass, entries of rows outside the frame are masked away
// a two-entry output (result register plus skid) keeps pix.ready registered;
// the whole pipeline holds only while both entries are full
// results trail the input by radius rows plus radius pixels, so padding
// beats after the frame drain the last results
//
module depth_clamp_erode_filter
	import dcef_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	dcef_pix_if.sink          pix,
	dcef_res_if.source        res
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [DIM_W-1:0]     cfg_width_q;
	logic [DIM_W-1:0]     cfg_height_q;
	logic [DEPTH_W-1:0]   cfg_floor_q;
	logic [DEPTH_W-1:0]   cfg_ceil_q;
	logic [RAD_W-1:0]     cfg_rad_q;
	logic [MASK_BITS-1:0] cfg_mask_q;

	logic     cfg_we;
	reg_idx_t cfg_idx;
	logic     geom_write;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:REG_ALIGN]);
	assign cfg_we  = psel && penable && pwrite;

	// a geometry write restarts the frame
	assign geom_write = cfg_we && (cfg_idx == REG_FRAME_WIDTH ||
		cfg_idx == REG_FRAME_HEIGHT || cfg_idx == REG_WINDOW_RADIUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= RST_WIDTH;
			cfg_height_q <= RST_HEIGHT;
			cfg_floor_q  <= RST_FLOOR;
			cfg_ceil_q   <= RST_CEILING;
			cfg_rad_q    <= RST_RADIUS;
			cfg_mask_q   <= RST_MASK;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FRAME_WIDTH:   cfg_width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT:  cfg_height_q <= pwdata[DIM_W-1:0];
				REG_DEPTH_FLOOR:   cfg_floor_q  <= pwdata[DEPTH_W-1:0];
				REG_DEPTH_CEILING: cfg_ceil_q   <= pwdata[DEPTH_W-1:0];
				REG_WINDOW_RADIUS: cfg_rad_q    <= pwdata[RAD_W-1:0];
				REG_WINDOW_MASK:   cfg_mask_q   <= pwdata[MASK_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FRAME_WIDTH:   prdata = APB_DW'(cfg_width_q);
			REG_FRAME_HEIGHT:  prdata = APB_DW'(cfg_height_q);
			REG_DEPTH_FLOOR:   prdata = APB_DW'(cfg_floor_q);
			REG_DEPTH_CEILING: prdata = APB_DW'(cfg_ceil_q);
			REG_WINDOW_RADIUS: prdata = APB_DW'(cfg_rad_q);
			REG_WINDOW_MASK:   prdata = APB_DW'(cfg_mask_q);
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// effective geometry: zero counts as one, oversize saturates
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [RAD_W-1:0] rad;
	logic [LAG_W-1:0] lag;
	depth_t           lo;
	depth_t           hi;

	always_comb begin
		if (cfg_width_q == '0)
			w_eff = DIM_W'(1);
		else if (cfg_width_q > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = cfg_width_q;

		if (cfg_height_q == '0)
			h_eff = DIM_W'(1);
		else if (cfg_height_q > DIM_W'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = cfg_height_q;

		rad = (cfg_rad_q > RAD_W'(MAX_RAD)) ? RAD_W'(MAX_RAD) : cfg_rad_q;
	end

	// beats between a pixel and the result centred on it
	assign lag = LAG_W'(w_eff) * LAG_W'(rad) + LAG_W'(rad);
	assign lo  = cfg_floor_q[DEPTH_BITS-1:0];
	assign hi  = cfg_ceil_q[DEPTH_BITS-1:0];

	// window selection, slot [i][j] = row i up from newest, column j back
	logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0] sel_mask;

	always_comb begin
		int bit_idx;
		sel_mask = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			for (int j = 0; j < MAX_WINDOW; j++) begin
				bit_idx = (MASK_CENTRE + int'(rad) - i) * MASK_SIDE +
					(MASK_CENTRE + int'(rad) - j);
				if (i <= 2 * int'(rad) && j <= 2 * int'(rad))
					sel_mask[i][j] = cfg_mask_q[bit_idx];
			end
		end
	end

	// ------------------------------------------------------------------
	// output side: result register plus skid, pipeline holds on full skid
	// ------------------------------------------------------------------
	logic   out_valid_q;
	depth_t out_depth_q;
	logic   out_done_q;
	logic   skid_valid_q;
	depth_t skid_depth_q;
	logic   skid_done_q;
	logic   en;
	logic   take;

	assign en        = !skid_valid_q;
	assign take      = out_valid_q && res.ready;
	assign pix.ready = en;

	// ------------------------------------------------------------------
	// stage 0: position counters and pixel clamp
	// ------------------------------------------------------------------
	logic [COL_W-1:0]    in_col_q;
	logic [IN_ROW_W-1:0] in_row_q;
	logic [LAG_W-1:0]    pre_cnt_q;
	logic                primed_q;
	logic [COL_W-1:0]    out_col_q;
	logic [ROW_W-1:0]    out_row_q;

	logic   acc;
	logic   pixel_phase;
	logic   tick;
	logic   in_col_last;
	logic   out_col_last;
	logic   emit0;
	logic   done0;
	depth_t raw;
	depth_t clamped;

	assign acc         = pix.valid && en;
	assign pixel_phase = in_row_q < IN_ROW_W'(h_eff);
	// a flush beat inside the frame neither advances nor yields a result
	assign tick        = acc && !(pixel_phase && pix.flush_tick);
	assign in_col_last = (DIM_W'(in_col_q) + DIM_W'(1)) >= w_eff;
	assign out_col_last = DIM_W'(out_col_q) == (w_eff - DIM_W'(1));
	assign emit0       = primed_q || (pre_cnt_q == lag);
	assign done0       = out_col_last && (DIM_W'(out_row_q) == (h_eff - DIM_W'(1)));
	assign raw         = pix.depth_mm[DEPTH_BITS-1:0];
	assign clamped     = (raw == '0 || raw < lo || raw > hi) ? hi : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			pre_cnt_q <= '0;
			primed_q  <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (geom_write || (tick && emit0 && done0)) begin
			// frame restart, also after the last result of a frame
			in_col_q  <= '0;
			in_row_q  <= '0;
			pre_cnt_q <= '0;
			primed_q  <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (tick) begin
			if (in_col_last) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + IN_ROW_W'(1);
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end

			// count beats until the first result is due
			if (!primed_q) begin
				if (pre_cnt_q == lag)
					primed_q <= 1'b1;
				else
					pre_cnt_q <= pre_cnt_q + LAG_W'(1);
			end

			if (emit0) begin
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: line store read data, write back, window clip tests
	// ------------------------------------------------------------------
	logic             s1_valid;
	logic             s1_emit;
	logic             s1_done;
	depth_t           s1_pix;
	logic [COL_W-1:0] s1_addr;
	logic [ROW_W-1:0] s1_row;
	logic [COL_W-1:0] s1_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_emit  <= 1'b0;
			s1_done  <= 1'b0;
		end else if (en) begin
			s1_valid <= tick;
			s1_emit  <= tick && emit0;
			s1_done  <= tick && emit0 && done0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_pix  <= clamped;
			s1_addr <= in_col_q;
			s1_row  <= out_row_q;
			s1_col  <= out_col_q;
		end
	end

	// line store: six rows above the current one, one word per column
	lb_word_t lb_mem [MAX_WIDTH];
	lb_word_t lb_rd_q;
	lb_word_t byp_data_q;
	logic     byp_q;
	lb_word_t lb_above;
	lb_word_t lb_wr;
	win_col_t col_new;

	// the read and the write of one column meet when the row is one pixel wide
	assign lb_above = byp_q ? byp_data_q : lb_rd_q;

	always_comb begin
		lb_wr[0]   = s1_pix;
		col_new[0] = s1_pix;
		for (int k = 1; k < LB_ROWS; k++)
			lb_wr[k] = lb_above[k-1];
		for (int k = 1; k < MAX_WINDOW; k++)
			col_new[k] = lb_above[k-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lb_rd_q <= lb_mem[in_col_q];
			if (s1_valid)
				lb_mem[s1_addr] <= lb_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byp_q <= 1'b0;
		else if (en)
			byp_q <= s1_valid && (s1_addr == in_col_q);
	end

	always_ff @(posedge clk) begin
		if (en)
			byp_data_q <= lb_wr;
	end

	// clip the window to the frame, centre plus radius is the newest slot
	logic [POS_W-1:0]      row_plus;
	logic [POS_W-1:0]      col_plus;
	logic [MAX_WINDOW-1:0] row_ok;
	logic [MAX_WINDOW-1:0] col_ok;

	assign row_plus = POS_W'(s1_row) + POS_W'(rad);
	assign col_plus = POS_W'(s1_col) + POS_W'(rad);

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			row_ok[i] = (row_plus >= POS_W'(i)) &&
				(row_plus < POS_W'(h_eff) + POS_W'(i));
			col_ok[i] = (col_plus >= POS_W'(i)) &&
				(col_plus < POS_W'(w_eff) + POS_W'(i));
		end
	end

	// ------------------------------------------------------------------
	// stage 2: window registers, per-column masked minimum
	// ------------------------------------------------------------------
	win_col_t              win_q [MAX_WINDOW];
	logic                  s2_emit;
	logic                  s2_done;
	logic [MAX_WINDOW-1:0] s2_row_ok;
	logic [MAX_WINDOW-1:0] s2_col_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_emit <= 1'b0;
			s2_done <= 1'b0;
		end else if (en) begin
			s2_emit <= s1_emit;
			s2_done <= s1_done;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2_row_ok <= row_ok;
			s2_col_ok <= col_ok;
			if (s1_valid) begin
				win_q[0] <= col_new;
				for (int j = 1; j < MAX_WINDOW; j++)
					win_q[j] <= win_q[j-1];
			end
		end
	end

	depth_t cmin [MAX_WINDOW];

	always_comb begin
		for (int j = 0; j < MAX_WINDOW; j++) begin
			cmin[j] = '1;
			for (int i = 0; i < MAX_WINDOW; i++) begin
				if (s2_row_ok[i] && s2_col_ok[j] && sel_mask[i][j] &&
						win_q[j][i] < cmin[j])
					cmin[j] = win_q[j][i];
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 3: minimum across columns, into the output register or skid
	// ------------------------------------------------------------------
	depth_t s3_cmin [MAX_WINDOW];
	logic   s3_emit;
	logic   s3_done;
	depth_t wmin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_emit <= 1'b0;
			s3_done <= 1'b0;
		end else if (en) begin
			s3_emit <= s2_emit;
			s3_done <= s2_done;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			s3_cmin <= cmin;
	end

	// an empty window leaves the all-ones depth
	always_comb begin
		wmin = '1;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			if (s3_cmin[j] < wmin)
				wmin = s3_cmin[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take)
				skid_valid_q <= 1'b0;
		end else if (s3_emit) begin
			if (!out_valid_q || take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_depth_q <= skid_depth_q;
				out_done_q  <= skid_done_q;
			end
		end else if (s3_emit) begin
			if (!out_valid_q || take) begin
				out_depth_q <= wmin;
				out_done_q  <= s3_done;
			end else begin
				skid_depth_q <= wmin;
				skid_done_q  <= s3_done;
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.eroded_depth_mm = DEPTH_W'(out_depth_q);
	assign res.frame_done      = out_done_q;

endmodule

// File: design/dcef_checker.sv
// ----------------------------------------------------------------------------
// dcef_checker: port-level checks of the depth clamp and erosion filter
// result beat hand-off and input stall behaviour
// ----------------------------------------------------------------------------
module dcef_checker
	import dcef_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               pix_valid,
	input logic               pix_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [DEPTH_W-1:0] eroded_depth_mm,
	input logic               frame_done
);

	// a result beat stays offered until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat withdrawn before hand-off");

	// and keeps its payload meanwhile
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(eroded_depth_mm) && $stable(frame_done))
		else $error("result payload changed while stalled");

	// input stalls only with a result waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> res_valid)
		else $error("input stalled with no result pending");

	// a stall starts only after a refused result beat
	a_stall_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pix_ready) |-> $past(res_valid && !res_ready))
		else $error("input stall without output back-pressure");

	// one taken result frees the input again
	a_stall_exit: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready && res_ready |=> pix_ready)
		else $error("input still stalled after result hand-off");

endmodule

bind depth_clamp_erode_filter dcef_checker u_dcef_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pix_valid       (pix.valid),
	.pix_ready       (pix.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.eroded_depth_mm (res.eroded_depth_mm),
	.frame_done      (res.frame_done)
);
